>>> design/tsrg_pkg.sv
// tsrg_pkg: shared types and command codes for the step ramp generator
// no dependencies
`timescale 1ns / 1ps
package tsrg_pkg;
    typedef enum logic [2:0] {
        K_TICK = 3'd0, K_MOVE = 3'd1, K_STOP = 3'd2,
        K_ZERO = 3'd3, K_ENABLE = 3'd4, K_DISABLE = 3'd5
    } t_kind;

    localparam logic [2:0] REG_FEED = 3'd0, REG_ACCEL = 3'd1, REG_VMIN = 3'd2,
        REG_MAXSTEP = 3'd3, REG_STALLV = 3'd4, REG_ARM = 3'd5,
        REG_SMIN = 3'd6, REG_SMAX = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] target_steps;
        logic        diag_high;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  steps_emitted;
        logic        direction;
        logic        dir_changed;
        logic [31:0] position;
        logic [23:0] velocity;
        logic        moving;
        logic        enabled;
        logic        stalled;
        logic        accepted;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_item;
endpackage

>>> design/tsrg_if.sv
// tsrg_if: valid/ready channel interfaces for items and configuration
// depends on tsrg_pkg
`timescale 1ns / 1ps
interface tsrg_in_if;
    import tsrg_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsrg_out_if;
    import tsrg_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsrg_cfg_if;
    import tsrg_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/tsrg_fifo.sv
// tsrg_fifo: two-entry item queue between front and back parts
// depends on tsrg_pkg
`timescale 1ns / 1ps
module tsrg_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tsrg_pkg::t_in_item i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output tsrg_pkg::t_in_item o_data
);
    import tsrg_pkg::*;
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> design/tsrg_div.sv
// tsrg_div: restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
module tsrg_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_sh;

    assign w_sh   = {r_rem[W-1:0], r_q[W-1]};
    assign o_done = r_busy && (r_cnt == CW'(0));
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_cnt <= CW'(W);
            r_q <= i_num; r_d <= i_den; r_rem <= '0;
        end else if (r_busy) begin
            if (r_cnt == CW'(0)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
                if (w_sh >= {1'b0, r_d}) begin
                    r_rem <= w_sh - {1'b0, r_d};
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
            end
        end
    end
endmodule

>>> design/tsrg_core.sv
// tsrg_core: back part, executes one item at a time and holds axis state
// depends on tsrg_pkg and tsrg_div
`timescale 1ns / 1ps
module tsrg_core #(
    parameter int POSITION_BITS = 32,
    parameter int FRAC_BITS     = 16,
    parameter bit STALL_HALT    = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  tsrg_pkg::t_in_item  i_q_data,
    output logic                o_q_pop,
    input  logic                i_cfg_we,
    input  tsrg_pkg::t_cfg_item i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output tsrg_pkg::t_out_item o_data
);
    import tsrg_pkg::*;
    localparam int PB = POSITION_BITS;
    localparam int DW = 64;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MUL = 5'b00010, S_DIV = 5'b00100,
        S_EXEC = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_st;
    // configuration
    logic [23:0] r_feed, r_accel, r_vmin, r_stallv;
    logic [7:0]  r_maxstep;
    logic [15:0] r_armt;
    logic signed [31:0] r_smin, r_smax;
    // axis state
    logic [PB-1:0] r_pos, r_tgt;
    logic [23:0]   r_vel, r_frac;
    logic [15:0]   r_arm;
    logic          r_dir, r_en, r_latch;
    // item in work
    t_in_item  r_item;
    logic [47:0] r_vsq;
    t_out_item r_out;

    logic        w_div_start, w_div_done;
    logic [DW-1:0] w_num, w_den, w_quo;
    logic [DW-1:0] w_bden;

    assign w_bden = DW'({r_accel, 1'b0}) << FRAC_BITS;
    // stop rounds: (2*vsq + den) / (2*den)
    assign w_num = (r_item.kind == K_STOP) ? ((DW'(r_vsq) << 1) + w_bden) : DW'(r_vsq);
    assign w_den = (r_item.kind == K_STOP) ? (w_bden << 1) : w_bden;
    assign w_div_start = (r_st == S_MUL);

    tsrg_div #(.W(DW)) u_div (
        .i_clk, .i_rst_n, .i_start(w_div_start), .i_num(w_num), .i_den(w_den),
        .o_done(w_div_done), .o_quo(w_quo)
    );

    assign o_q_pop = (r_st == S_IDLE) && !i_q_empty;
    assign o_valid = (r_st == S_OUT);
    assign o_data  = r_out;

    // tick datapath
    logic signed [PB:0] w_rem;
    logic [PB:0]   w_dist;
    logic          w_want_p, w_want_z, w_bleed, w_brk;
    logic [24:0]   w_vd, w_vu, w_acc;
    logic [23:0]   w_vnew;
    logic [24-FRAC_BITS:0] w_n0;
    logic [PB:0]   w_n1;
    logic [7:0]    w_n;
    logic signed [PB:0] w_pe;

    always_comb begin
        w_rem    = $signed({r_tgt[PB-1], r_tgt}) - $signed({r_pos[PB-1], r_pos});
        w_want_z = (w_rem == '0);
        w_want_p = !w_rem[PB] && !w_want_z;
        w_bleed  = w_want_z || (w_want_p != r_dir);
        w_dist   = w_rem[PB] ? (PB+1)'(-w_rem) : (PB+1)'(w_rem);
        w_brk    = w_bleed || (r_accel == '0) || (DW'(w_dist) <= w_quo);
        w_vd     = {1'b0, r_vel} - {1'b0, r_accel};
        w_vu     = {1'b0, r_vel} + {1'b0, r_accel};
        if (w_brk)
            w_vnew = (w_vd[24] || w_vd[23:0] < r_vmin) ? r_vmin : w_vd[23:0];
        else
            w_vnew = (w_vu > {1'b0, r_feed}) ? r_feed : w_vu[23:0];
        w_acc = {1'b0, r_frac} + {1'b0, w_vnew};
        w_n0  = w_acc[24:FRAC_BITS];
        w_n1  = (PB+1)'(w_n0);
        if (!w_bleed && w_n1 > w_dist) w_n1 = w_dist;
        w_n   = (w_n1 > (PB+1)'(r_maxstep)) ? r_maxstep : w_n1[7:0];
        w_pe  = $signed({r_pos[PB-1], r_pos});
    end

    logic [PB-1:0] w_stopd;
    assign w_stopd = (r_accel == '0) ? '0 : w_quo[PB-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            case (i_cfg.index)
                REG_FEED:    r_feed    <= i_cfg.data[23:0];
                REG_ACCEL:   r_accel   <= i_cfg.data[23:0];
                REG_VMIN:    r_vmin    <= i_cfg.data[23:0];
                REG_MAXSTEP: r_maxstep <= i_cfg.data[7:0];
                REG_STALLV:  r_stallv  <= i_cfg.data[23:0];
                REG_ARM:     r_armt    <= i_cfg.data[15:0];
                REG_SMIN:    r_smin    <= i_cfg.data;
                REG_SMAX:    r_smax    <= i_cfg.data;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_feed <= 24'd131072; r_accel <= 24'd655; r_vmin <= 24'd655;
            r_maxstep <= 8'd8; r_stallv <= 24'd1310; r_armt <= 16'd200;
            r_smin <= 32'sh80000000; r_smax <= 32'sh7FFFFFFF;
            r_pos <= '0; r_tgt <= '0; r_vel <= '0; r_frac <= '0; r_arm <= '0;
            r_dir <= 1'b1; r_en <= 1'b1; r_latch <= 1'b0;
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_item <= i_q_data;
                        r_st   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) r_st <= S_EXEC;
                end
                S_EXEC: begin
                    logic [7:0] v_steps;
                    logic       v_flip, v_acc;
                    logic [PB-1:0] v_pos, v_tgt;
                    logic [23:0] v_vel, v_frac;
                    logic [15:0] v_arm;
                    logic        v_dir, v_en, v_latch;
                    v_steps = '0; v_flip = 1'b0; v_acc = 1'b1;
                    v_pos = r_pos; v_tgt = r_tgt; v_vel = r_vel; v_frac = r_frac;
                    v_arm = r_arm; v_dir = r_dir; v_en = r_en; v_latch = r_latch;
                    case (r_item.kind)
                        K_TICK: begin
                            if (v_arm != 16'hFFFF) v_arm = v_arm + 16'd1;
                            if (w_bleed && r_vel <= r_vmin) begin
                                v_vel = '0; v_frac = '0;
                                if (!w_want_z) begin
                                    v_dir = w_want_p; v_flip = 1'b1;
                                end
                            end else if (!r_en) begin
                                v_vel = '0; v_frac = '0;
                            end else if (!r_latch && r_item.diag_high &&
                                         r_vel >= r_stallv && v_arm >= r_armt) begin
                                v_latch = 1'b1;
                                if (STALL_HALT) begin
                                    v_tgt = r_pos; v_vel = '0; v_frac = '0;
                                end
                            end else begin
                                v_vel  = w_vnew;
                                v_frac = w_acc[23:0];
                                if (w_n0 != '0) begin
                                    v_frac = 24'(w_acc[FRAC_BITS-1:0]);
                                    if (!w_bleed && w_n1 == w_dist &&
                                        (PB+1)'(w_n0) > w_dist) v_frac = '0;
                                    v_steps = w_n;
                                    v_pos = r_dir ? PB'(w_pe + (PB+1)'(w_n))
                                                  : PB'(w_pe - (PB+1)'(w_n));
                                end
                            end
                        end
                        K_MOVE: begin
                            if (!r_en || $signed(r_item.target_steps) < r_smin ||
                                $signed(r_item.target_steps) > r_smax) begin
                                v_acc = 1'b0;
                            end else begin
                                v_tgt = PB'($signed(r_item.target_steps));
                                v_latch = 1'b0; v_arm = '0;
                            end
                        end
                        K_STOP: v_tgt = r_dir ? r_pos + w_stopd : r_pos - w_stopd;
                        K_ZERO: begin
                            v_pos = '0; v_tgt = '0; v_frac = '0; v_latch = 1'b0;
                        end
                        K_ENABLE: begin
                            v_latch = 1'b0; v_arm = '0; v_en = 1'b1;
                        end
                        K_DISABLE: begin
                            v_tgt = r_pos; v_en = 1'b0;
                        end
                        default: ;
                    endcase
                    r_pos <= v_pos; r_tgt <= v_tgt; r_vel <= v_vel; r_frac <= v_frac;
                    r_arm <= v_arm; r_dir <= v_dir; r_en <= v_en; r_latch <= v_latch;
                    r_out.steps_emitted <= v_steps;
                    r_out.direction     <= v_dir;
                    r_out.dir_changed   <= v_flip;
                    r_out.position      <= 32'($signed(v_pos));
                    r_out.velocity      <= v_vel;
                    r_out.moving        <= (v_pos != v_tgt) || (v_vel != '0);
                    r_out.enabled       <= v_en;
                    r_out.stalled       <= v_latch;
                    r_out.accepted      <= v_acc;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE) r_vsq <= 48'(r_vel) * 48'(r_vel);
    end
endmodule

>>> design/trapezoidal_step_ramp_generator_unit.sv
// trapezoidal step ramp generator: one result item per input item
// each item runs the 64-step braking-distance divider in the back part
// throughput: one item at a time in the back part, a 2-entry queue in front
// accepts items while the back part works or its result waits
// synchronous active-low reset restores default configuration and axis state
`timescale 1ns / 1ps
module trapezoidal_step_ramp_generator_unit #(
    parameter int POSITION_BITS = 32,
    parameter int FRAC_BITS     = 16,
    parameter bit STALL_HALT    = 1'b1
) (
    input logic    i_clk,
    input logic    i_rst_n,
    tsrg_in_if.sink    in_ch,
    tsrg_cfg_if.sink   cfg_ch,
    tsrg_out_if.source out_ch
);
    import tsrg_pkg::*;

    logic     w_full, w_empty, w_pop;
    t_in_item w_qd;

    // front part: queue takes items whenever it has room
    assign in_ch.ready  = !w_full;
    // configuration is always taken
    assign cfg_ch.ready = 1'b1;

    tsrg_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(in_ch.valid && !w_full), .i_data(in_ch.data), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_qd)
    );

    // back part: motion state, divider and result register
    tsrg_core #(
        .POSITION_BITS(POSITION_BITS), .FRAC_BITS(FRAC_BITS), .STALL_HALT(STALL_HALT)
    ) u_core (
        .i_clk, .i_rst_n,
        .i_q_empty(w_empty), .i_q_data(w_qd), .o_q_pop(w_pop),
        .i_cfg_we(cfg_ch.valid), .i_cfg(cfg_ch.data),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_data(out_ch.data)
    );
endmodule
